FILE: design/repeating_decimal_to_fraction_unit_defines.svh
// Assertion macros shared by the repeating decimal to fraction checker.
`ifndef REPEATING_DECIMAL_TO_FRACTION_UNIT_DEFINES_SVH
`define REPEATING_DECIMAL_TO_FRACTION_UNIT_DEFINES_SVH

// Check a consequence in the same cycle.
`define RDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the following cycle.
`define RDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rdf_pkg.sv
// Types, constants and microcode table of the repeating decimal to fraction unit.
package rdf_pkg;

   // Field and datapath widths: a 30-bit block has at most ten digits, 10^10 fits 34 bits.
   localparam int FIELD_W    = 30;
   localparam int DATA_W     = 34;
   localparam int MAX_DIGITS = 9;

   // Power of ten on 64 bits, evaluated at elaboration.
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   // Largest block accepted; with a digit limit above nine no 30-bit value saturates.
   localparam logic [FIELD_W-1:0] SAT_LIMIT =
      (MAX_DIGITS < 10) ? FIELD_W'(pow10(MAX_DIGITS) - 64'd1) : '1;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SCALE,
      OP_SETUP,
      OP_DIV_AB,
      OP_EUC_UPD,
      OP_DIV_NUM,
      OP_NUM_UPD,
      OP_DIV_DEN,
      OP_FINISH
   } op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_IDLE,
      C_N_GE_P,
      C_B_ZERO,
      C_DIV_BUSY
   } cond_type;

   localparam int PC_W        = 4;
   localparam int UCODE_DEPTH = 2 ** PC_W;

   typedef logic [PC_W-1:0] pc_type;

   // Program steps that are jump targets.
   localparam pc_type STEP_IDLE     = PC_W'(0);
   localparam pc_type STEP_COUNT    = PC_W'(1);
   localparam pc_type STEP_TEST     = PC_W'(3);
   localparam pc_type STEP_WAIT_EUC = PC_W'(5);
   localparam pc_type STEP_DIV_NUM  = PC_W'(7);
   localparam pc_type STEP_WAIT_NUM = PC_W'(8);
   localparam pc_type STEP_WAIT_DEN = PC_W'(10);

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_word_type;

   // Control from sequencer to datapath.
   typedef struct packed {
      op_type op;
   } ctrl_type;

   // Flags from datapath to sequencer.
   typedef struct packed {
      logic n_ge_p;
      logic b_zero;
      logic div_busy;
   } stat_type;

   // Microcode program.
   localparam ucode_word_type UCODE [UCODE_DEPTH] = '{
      '{OP_LOAD,    C_IDLE,     STEP_IDLE},
      '{OP_SCALE,   C_N_GE_P,   STEP_COUNT},
      '{OP_SETUP,   C_NONE,     STEP_IDLE},
      '{OP_NOP,     C_B_ZERO,   STEP_DIV_NUM},
      '{OP_DIV_AB,  C_NONE,     STEP_IDLE},
      '{OP_EUC_UPD, C_DIV_BUSY, STEP_WAIT_EUC},
      '{OP_NOP,     C_ALWAYS,   STEP_TEST},
      '{OP_DIV_NUM, C_NONE,     STEP_IDLE},
      '{OP_NUM_UPD, C_DIV_BUSY, STEP_WAIT_NUM},
      '{OP_DIV_DEN, C_NONE,     STEP_IDLE},
      '{OP_FINISH,  C_DIV_BUSY, STEP_WAIT_DEN},
      '{OP_NOP,     C_ALWAYS,   STEP_IDLE},
      '{OP_NOP,     C_ALWAYS,   STEP_IDLE},
      '{OP_NOP,     C_ALWAYS,   STEP_IDLE},
      '{OP_NOP,     C_ALWAYS,   STEP_IDLE},
      '{OP_NOP,     C_ALWAYS,   STEP_IDLE}
   };

endpackage

FILE: design/rdf_div.sv
// Restoring divider, one quotient bit per cycle.
module rdf_div #(
   parameter int W = 34
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [W:0]       trial;
   logic [W:0]       diff;

   // Shift in the next dividend bit and try the subtraction.
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // Hold payload without reset.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/rdf_sequencer.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module rdf_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rdf_pkg::stat_type stat,
   output rdf_pkg::ctrl_type ctrl,
   output logic              busy
);
   import rdf_pkg::*;

   pc_type         pc_ff, pc_in;
   ucode_word_type word;
   logic           take;

   assign word = UCODE[pc_ff];

   // Evaluate the jump condition of the current step.
   always_comb begin
      unique case (word.cond)
         C_NONE:     take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_IDLE:     take = !start;
         C_N_GE_P:   take = stat.n_ge_p;
         C_B_ZERO:   take = stat.b_zero;
         C_DIV_BUSY: take = stat.div_busy;
         default:    take = 1'b1;
      endcase
   end

   // Jump or advance.
   assign pc_in = take ? word.target : pc_ff + PC_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op = word.op;
   assign busy    = (pc_ff != STEP_IDLE);

endmodule

FILE: design/rdf_datapath.sv
// Datapath: digit count, Euclid registers, shared divider and result registers.
module rdf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rdf_pkg::ctrl_type             ctrl,
   input  logic [rdf_pkg::FIELD_W-1:0]   req_repeat_digits,
   output rdf_pkg::stat_type             stat,
   output logic                          rsp_valid,
   output logic [rdf_pkg::FIELD_W-1:0]   rsp_numerator,
   output logic [rdf_pkg::FIELD_W-1:0]   rsp_denominator
);
   import rdf_pkg::*;

   logic [FIELD_W-1:0] n_ff, n_in;
   logic [DATA_W-1:0]  p_ff, p_in;
   logic [DATA_W-1:0]  d_ff, d_in;
   logic [DATA_W-1:0]  a_ff, a_in;
   logic [DATA_W-1:0]  b_ff, b_in;
   logic [FIELD_W-1:0] q_ff, q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_num_ff, rsp_num_in;
   logic [FIELD_W-1:0] rsp_den_ff, rsp_den_in;

   logic               div_start;
   logic [DATA_W-1:0]  div_dividend;
   logic [DATA_W-1:0]  div_divisor;
   logic               div_busy;
   logic [DATA_W-1:0]  div_quot;
   logic [DATA_W-1:0]  div_rem;
   logic [DATA_W-1:0]  n_wide;
   logic               n_ge_p;

   assign n_wide = DATA_W'(n_ff);
   assign n_ge_p = (n_wide >= p_ff);

   rdf_div #(
      .W (DATA_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Decode the operation of the current step.
   always_comb begin
      n_in         = n_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      q_in         = q_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = b_ff;
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            // Clamp an overlong block to all nines.
            n_in = (req_repeat_digits > SAT_LIMIT) ? SAT_LIMIT : req_repeat_digits;
            p_in = DATA_W'(10);
         end
         OP_SCALE: begin
            if (n_ge_p) begin
               p_in = (p_ff << 3) + (p_ff << 1);
            end
         end
         OP_SETUP: begin
            d_in = p_ff - DATA_W'(1);
            a_in = n_wide;
            b_in = p_ff - DATA_W'(1);
         end
         OP_DIV_AB: begin
            div_start = 1'b1;
         end
         OP_EUC_UPD: begin
            if (!div_busy) begin
               a_in = b_ff;
               b_in = div_rem;
            end
         end
         OP_DIV_NUM: begin
            div_start    = 1'b1;
            div_dividend = n_wide;
            div_divisor  = a_ff;
         end
         OP_NUM_UPD: begin
            if (!div_busy) begin
               q_in = div_quot[FIELD_W-1:0];
            end
         end
         OP_DIV_DEN: begin
            div_start    = 1'b1;
            div_dividend = d_ff;
            div_divisor  = a_ff;
         end
         OP_FINISH: begin
            if (!div_busy) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = q_ff;
               rsp_den_in   = div_quot[FIELD_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Hold payload registers.
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      q_ff       <= q_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.n_ge_p   = n_ge_p;
   assign stat.b_zero   = (b_ff == '0);
   assign stat.div_busy = div_busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_numerator   = rsp_num_ff;
   assign rsp_denominator = rsp_den_ff;

endmodule

FILE: design/repeating_decimal_to_fraction_unit.sv
// An accepted start runs the power-of-ten scaling over the digits of the block, then the Euclid
// remainder steps, each one a divide, and then the numerator and denominator divides.
// All of these divides run through the shared bit-serial divider.
// Throughput: one item at a time; busy falls the cycle after the strobe, then start is taken.
// Reset (synchronous, active high) returns the sequencer to idle and drops the strobe.
// Results are strobed for one cycle; the receiver cannot stall them.
module repeating_decimal_to_fraction_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rdf_pkg::FIELD_W-1:0] req_repeat_digits,
   output logic                        rsp_valid,
   output logic [rdf_pkg::FIELD_W-1:0] rsp_numerator,
   output logic [rdf_pkg::FIELD_W-1:0] rsp_denominator
);
   import rdf_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   // Step through the microcode program.
   rdf_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // Execute each step's operation.
   rdf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_repeat_digits (req_repeat_digits),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_numerator     (rsp_numerator),
      .rsp_denominator   (rsp_denominator)
   );

endmodule

FILE: design/rdf_checker.sv
// Port checker for the repeating decimal to fraction unit, with its bind.
`include "repeating_decimal_to_fraction_unit_defines.svh"

module rdf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [rdf_pkg::FIELD_W-1:0] req_repeat_digits,
   input logic                        rsp_valid,
   input logic [rdf_pkg::FIELD_W-1:0] rsp_numerator,
   input logic [rdf_pkg::FIELD_W-1:0] rsp_denominator
);
   import rdf_pkg::*;

   logic [FIELD_W:0] port_sum;

   // Fold the payload in so every port is observed.
   assign port_sum = {1'b0, req_repeat_digits} + {1'b0, rsp_numerator};

   // An accepted beat makes the unit busy.
   `RDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   // A result is strobed only while the item is still in progress.
   `RDF_ASSERT_NOW(a_strobe_busy, rsp_valid, busy, "result strobed while idle")
   // One strobe per item, and the unit is ready right after it.
   `RDF_ASSERT_NEXT(a_strobe_end, rsp_valid, !rsp_valid && !busy, "strobe not a single end beat")
   // A reduced denominator is never zero.
   `RDF_ASSERT_NOW(a_den_nonzero, rsp_valid && (port_sum[FIELD_W] || !port_sum[FIELD_W]),
      rsp_denominator != '0, "zero denominator")

endmodule

bind repeating_decimal_to_fraction_unit rdf_checker u_rdf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_repeat_digits (req_repeat_digits),
   .rsp_valid         (rsp_valid),
   .rsp_numerator     (rsp_numerator),
   .rsp_denominator   (rsp_denominator)
);

FILE: dv/repeating_decimal_to_fraction_unit_tb.sv
// Self-checking testbench for the repeating decimal to fraction unit.
`timescale 1ns / 100ps

module repeating_decimal_to_fraction_unit_tb;

   import rdf_pkg::*;

   typedef logic [FIELD_W-1:0] field_type;

   // One expected reduced fraction, tagged with the block that produced it.
   typedef struct {
      field_type block;
      field_type numerator;
      field_type denominator;
   } fraction_type;

   localparam int DRAIN_CYCLES = 2000;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   field_type req_repeat_digits;
   logic      rsp_valid;
   field_type rsp_numerator;
   field_type rsp_denominator;

   fraction_type pending_fractions[$];
   int           mismatch_count;
   bit           quiet_run;

   repeating_decimal_to_fraction_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_repeat_digits(req_repeat_digits),
      .rsp_valid       (rsp_valid),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator)
   );

   // Toggle the clock every half period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Return ten to the given power on 64 bits.
   function automatic longint unsigned ten_power(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n && i < 19; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   // Work out the reduced fraction for one repeating block.
   function automatic fraction_type reduce_block(input field_type value);
      longint unsigned ceiling;
      longint unsigned num;
      longint unsigned den;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      int              digits;
      fraction_type    f;
      ceiling = ten_power(MAX_DIGITS) - 1;
      num     = value;
      // Clamp blocks that are too long to all nines.
      if (num > ceiling) begin
         num = ceiling;
      end
      // Count digits; zero still has one.
      digits = 0;
      a      = num;
      do begin
         digits++;
         a = a / 10;
      end while (a != 0);
      den = ten_power(digits) - 1;
      // Euclid on the pair.
      a = num;
      b = den;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      if (a == 0) begin
         a = 1;
      end
      f.block       = value;
      f.numerator   = FIELD_W'(num / a);
      f.denominator = FIELD_W'(den / a);
      return f;
   endfunction

   // Print a line for each of the first 100 mismatches and count every one.
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Offer one block until taken; start drops at random unless quiet_run is set.
   task automatic send_block(input field_type value);
      bit offer;
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         offer = quiet_run || ($urandom_range(99) >= 6);
         start             <= offer;
         req_repeat_digits <= offer ? value : field_type'($urandom);
         @(posedge clock);
         if (offer && !busy) begin
            taken = 1'b1;
         end
      end
      pending_fractions.push_back(reduce_block(value));
   endtask

   // Check every result beat against the oldest expected fraction.
   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d/%0d",
                                      rsp_numerator, rsp_denominator));
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_numerator !== want.numerator) begin
               report_mismatch($sformatf("block %0d numerator %0d, want %0d",
                                         want.block, rsp_numerator, want.numerator));
            end
            if (rsp_denominator !== want.denominator) begin
               report_mismatch($sformatf("block %0d denominator %0d, want %0d",
                                         want.block, rsp_denominator, want.denominator));
            end
         end
      end
   end

   // Zero, single digits, digit count boundaries such as 9 and 10, and the clamp edges.
   task automatic test_directed_cases();
      field_type blocks[$];
      blocks = '{0, 1, 3, 5, 9, 10, 12, 99, 333, 142857, 100000000, 123456789,
                 500000000, 909090909, 999999999, 1000000000, 536870912,
                 field_type'('1)};
      foreach (blocks[i]) begin
         send_block(blocks[i]);
      end
   endtask

   // Pick a digit count, then a block with exactly that many digits.
   task automatic test_digit_lengths(input int count);
      int              digits;
      longint unsigned lo;
      longint unsigned hi;
      repeat (count) begin
         digits = $urandom_range(MAX_DIGITS, 1);
         lo     = (digits == 1) ? 0 : ten_power(digits - 1);
         hi     = ten_power(digits) - 1;
         send_block(field_type'(lo + ({$urandom, $urandom} % (hi - lo + 1))));
      end
   endtask

   // Build blocks that share a factor with their denominator.
   task automatic test_shared_factors(input int count);
      longint unsigned factors[$];
      longint unsigned den;
      longint unsigned f;
      int              digits;
      factors = '{3, 9, 11, 27, 37, 41, 99, 101, 111, 271, 333, 999, 9091, 9901, 333667};
      repeat (count) begin
         digits = $urandom_range(MAX_DIGITS, 1);
         den    = ten_power(digits) - 1;
         f      = factors[$urandom_range(factors.size() - 1)];
         if (den % f == 0 && f > 1) begin
            send_block(field_type'((den / f) * $urandom_range(int'(f) - 1, 1)));
         end else begin
            send_block(field_type'(den / 3 * $urandom_range(2, 1)));
         end
      end
   endtask

   // Blocks longer than the digit limit clamp to all nines.
   task automatic test_saturation(input int count);
      longint unsigned lo;
      lo = ten_power(MAX_DIGITS);
      repeat (count) begin
         send_block(field_type'(lo + ($urandom % ((64'd1 << FIELD_W) - lo))));
      end
   endtask

   // Any 30-bit value, optionally with start never dropped.
   task automatic test_full_range(input int count, input bit no_gaps);
      quiet_run = no_gaps;
      repeat (count) begin
         if ($urandom_range(1)) begin
            send_block(field_type'($urandom));
         end else begin
            send_block(field_type'($urandom_range(999999999)));
         end
      end
      quiet_run = 1'b0;
   endtask

   // Run the tests in turn, then drain and judge.
   initial begin
      mismatch_count    = 0;
      quiet_run         = 1'b0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_repeat_digits <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_digit_lengths(200);
      test_shared_factors(100);
      test_saturation(30);
      test_full_range(60, 1'b1);
      test_full_range(60, 1'b0);

      start <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
